// File: rtl/core/svalloc_pkg.sv
// Shared types, constants and tables of the synth voice allocator.
package svalloc_pkg;

    localparam int VOICES     = 32;
    localparam int CHANNELS   = 16;
    localparam int VIDX_W     = $clog2(VOICES);
    localparam int CH_W       = 4;
    localparam int OWN_W      = 5;
    localparam int AV_W       = 6;
    localparam int CNT_W      = $clog2(VOICES + 1);
    localparam int OUT_IDX_W  = 5;
    localparam int SEL_W      = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [OWN_W-1:0] NO_OWNER  = OWN_W'(16);
    localparam logic [AV_W-1:0]  AV_RESET  = AV_W'(32);

    // Channel order walked when looking for a voice to steal.
    localparam logic [CH_W-1:0] PRIO_ORDER [CHANNELS] = '{
        4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd8, 4'd7,
        4'd6,  4'd5,  4'd4,  4'd3,  4'd2,  4'd1,  4'd0, 4'd9
    };

    // Voices each channel keeps before it becomes a steal target.
    localparam logic [CNT_W-1:0] QUOTA [CHANNELS] = '{
        CNT_W'(3), CNT_W'(3), CNT_W'(2), CNT_W'(2), CNT_W'(2), CNT_W'(2),
        CNT_W'(2), CNT_W'(2), CNT_W'(1), CNT_W'(4), CNT_W'(1), CNT_W'(1),
        CNT_W'(1), CNT_W'(1), CNT_W'(1), CNT_W'(1)
    };

    typedef enum logic [1:0] {
        FN_ALLOC  = 2'd0,
        FN_FINISH = 2'd1,
        FN_DETACH = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN
    } state_t;

    // Broadcast control from the sequencer to every voice cell.
    typedef struct packed {
        logic              clear;
        logic              finish;
        logic              detach;
        logic              grant;
        logic              look_free;
        logic [VIDX_W-1:0] sel;
        logic [OWN_W-1:0]  look_owner;
        logic [OWN_W-1:0]  new_owner;
    } cell_ctl_t;

endpackage

// File: rtl/core/svalloc_cell.sv
// One voice cell: busy flag, owner, and its link in the priority chain.
module svalloc_cell
    import svalloc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [VIDX_W-1:0] my_idx,
    input  logic              in_use,
    input  logic              claim_in,
    output logic              claim_out,
    output logic              hit,
    output logic              pick,
    output logic              busy
);

    logic             busy_reg;
    logic             busy_next;
    logic [OWN_W-1:0] owner_reg;
    logic [OWN_W-1:0] owner_next;
    logic             own_sel;

    assign own_sel   = (ctl.sel == my_idx);
    assign hit       = in_use & (ctl.look_free ? ~busy_reg : (owner_reg == ctl.look_owner));
    assign claim_out = claim_in | hit;
    assign pick      = hit & ~claim_in;
    assign busy      = busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        owner_next = owner_reg;
        if (ctl.clear)
        begin
            busy_next  = 1'b0;
            owner_next = NO_OWNER;
        end
        else if (ctl.grant && pick)
        begin
            busy_next  = 1'b1;
            owner_next = ctl.new_owner;
        end
        else if (ctl.finish && own_sel)
        begin
            busy_next = 1'b0;
        end
        else if (ctl.detach && own_sel)
        begin
            owner_next = NO_OWNER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            owner_reg <= NO_OWNER;
        end
        else
        begin
            busy_reg  <= busy_next;
            owner_reg <= owner_next;
        end
    end

    a_grant_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.grant && pick && !ctl.clear) |=> busy_reg)
        else $error("granted voice not marked busy");

    a_pick_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        pick |-> (claim_out && !claim_in))
        else $error("cell picked below an earlier claim");

    a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (!busy_reg && owner_reg == NO_OWNER))
        else $error("clear left voice state behind");

endmodule

// File: rtl/core/synth_voice_allocator.sv
// Top level of the synth voice allocator: sequencer, voice cell chain, output register.
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | func, channel, voice_sel (tdata)
//  m_axis    | out | m_axis_tvalid / m_axis_tready | voice_index, granted, stolen (tdata)
//  cfg       | in  | cfg_we                        | active_voices (cfg_wdata)
//
//  A word is taken in the idle state; in the free state the cell chain resolves a free voice,
//  finish, detach or clear and the result is loaded into the output register.
//  An allocate with no free voice walks the channel priority order, one channel per cycle
//  while the output register is free or being drained.
//  The next word is accepted while the previous result still waits in the output register;
//  the sequencer holds its result step while that register is full and not drained.
//  Reset frees every voice, detaches every owner and sets all 32 voices in use.
module synth_voice_allocator
    import svalloc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [1:0] func, [5:2] channel, [10:6] voice_sel, [15:11] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [4:0] voice_index, [5] granted, [6] stolen, [7] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [AV_W-1:0]       cfg_wdata
);

    state_t            state_reg, state_next;
    func_t             func_reg;
    logic [CH_W-1:0]   chan_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [CH_W-1:0]   prio_idx_reg, prio_idx_next;
    logic [AV_W-1:0]   active_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    cell_ctl_t         ctl;
    logic [VOICES-1:0] in_use;
    logic [VOICES-1:0] claim_in;
    logic [VOICES-1:0] claim_out;
    logic [VOICES-1:0] hit_vec;
    logic [VOICES-1:0] pick_vec;
    logic [VOICES-1:0] busy_vec;
    logic [VIDX_W-1:0] pick_idx;
    logic [CNT_W-1:0]  match_cnt;
    logic [CH_W-1:0]   scan_chan;
    logic              qualifies;
    logic              sel_ok;
    logic              out_free;
    logic              in_fire;

    logic                 res_load;
    logic [OUT_IDX_W-1:0] res_idx;
    logic                 res_granted;
    logic                 res_stolen;

    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_free = ~out_valid_reg | m_axis_tready;
    assign sel_ok   = (32'(sel_reg) < 32'(VOICES));

    // Voices below active_voices are in use; larger settings saturate at all voices.
    // Chain runs from the top voice down: a claim blocks every lower cell.
    genvar k;
    generate
        for (k = 0; k < VOICES; k++)
        begin : g_cell
            assign in_use[k] = (32'(k) < 32'(active_reg));
            if (k == VOICES - 1)
            begin : g_top
                assign claim_in[k] = 1'b0;
            end
            else
            begin : g_link
                assign claim_in[k] = claim_out[k+1];
            end

            svalloc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .my_idx    (VIDX_W'(k)),
                .in_use    (in_use[k]),
                .claim_in  (claim_in[k]),
                .claim_out (claim_out[k]),
                .hit       (hit_vec[k]),
                .pick      (pick_vec[k]),
                .busy      (busy_vec[k])
            );
        end
    endgenerate

    // Encode the one picked cell.
    always_comb
    begin
        pick_idx = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            if (pick_vec[i])
            begin
                pick_idx = pick_idx | VIDX_W'(i);
            end
        end
    end

    // During a steal scan every voice in use is busy, so the hits are the voices of
    // the scanned channel; more than its quota makes it the target.
    assign scan_chan = PRIO_ORDER[prio_idx_reg];
    assign match_cnt = CNT_W'($countones(hit_vec));
    assign qualifies = (match_cnt > QUOTA[scan_chan]);

    always_comb
    begin
        state_next     = state_reg;
        prio_idx_next  = prio_idx_reg;
        ctl            = '0;
        ctl.sel        = VIDX_W'(sel_reg);
        ctl.new_owner  = OWN_W'(chan_reg);
        ctl.look_owner = OWN_W'(scan_chan);
        ctl.look_free  = (state_reg != ST_SCAN);
        res_load       = 1'b0;
        res_idx        = '0;
        res_granted    = 1'b0;
        res_stolen     = 1'b0;
        s_axis_tready  = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_FREE;
                end
            end
            ST_FREE:
            begin
                if (out_free)
                begin
                    case (func_reg)
                        FN_ALLOC:
                        begin
                            if (claim_out[0])
                            begin
                                ctl.grant   = 1'b1;
                                res_load    = 1'b1;
                                res_granted = 1'b1;
                                res_idx     = OUT_IDX_W'(pick_idx);
                                state_next  = ST_IDLE;
                            end
                            else
                            begin
                                prio_idx_next = '0;
                                state_next    = ST_SCAN;
                            end
                        end
                        FN_FINISH:
                        begin
                            ctl.finish = sel_ok;
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        FN_DETACH:
                        begin
                            ctl.detach = sel_ok;
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        FN_CLEAR:
                        begin
                            ctl.clear  = 1'b1;
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (qualifies)
                    begin
                        // Steal the highest voice of the target channel.
                        ctl.grant   = 1'b1;
                        res_load    = 1'b1;
                        res_granted = 1'b1;
                        res_stolen  = 1'b1;
                        res_idx     = OUT_IDX_W'(pick_idx);
                        state_next  = ST_IDLE;
                    end
                    else if (prio_idx_reg == CH_W'(CHANNELS - 1))
                    begin
                        res_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        prio_idx_next = prio_idx_reg + CH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            prio_idx_reg <= '0;
            active_reg   <= AV_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            prio_idx_reg <= prio_idx_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
        end
    end

    // Capture the request word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg <= func_t'(s_axis_tdata[1:0]);
            chan_reg <= s_axis_tdata[5:2];
            sel_reg  <= s_axis_tdata[10:6];
        end
    end

    // Output register: load a result, drop it once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= {1'b0, res_stolen, res_granted, res_idx};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(pick_vec))
        else $error("more than one voice picked");

    a_stolen_granted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg[6]) |-> out_data_reg[5])
        else $error("steal reported without a grant");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[5]) |-> (out_data_reg[4:0] == '0))
        else $error("failed request carries a voice index");

    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.grant && claim_out[0]) |=> busy_vec[$past(pick_idx)])
        else $error("granted voice not busy afterwards");

endmodule
